FILE: rtl/gated_slew_limited_ema_filter_unit_macros.svh
// Assertion macros for the filter unit checker.
`ifndef GATED_SLEW_LIMITED_EMA_FILTER_UNIT_MACROS_SVH
`define GATED_SLEW_LIMITED_EMA_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GSLEF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define GSLEF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gslef_pkg.sv
// Shared types and constants of the gated slew-limited EMA filter.
package gslef_pkg;

	localparam int ADC_W     = 12;
	localparam int TEMP_W    = 18;
	localparam int STATUS_W  = 2;
	localparam int ALPHA_W   = 9;
	localparam int STEP_W    = 16;
	localparam int OFFSET_W  = 13;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 4;

	localparam int SAMPLES_PER_READING_DEF = 8;
	localparam int CONV_SHIFT = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 9'd51;
	localparam logic [ALPHA_W-1:0]  ALPHA_ONE      = 9'd256;
	localparam logic [STEP_W-1:0]   STEP_LIMIT_RST = 16'd384;
	localparam logic [STEP_W-1:0]   OUTLIER_RST    = 16'd5120;
	localparam logic [OFFSET_W-1:0] OFFSET_RST     = 13'd512;

	typedef enum logic [STATUS_W-1:0] {
		ST_FIRST   = 2'd0,
		ST_NORMAL  = 2'd1,
		ST_SLEW    = 2'd2,
		ST_OUTLIER = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_ALPHA      = 2'd0,
		REG_STEP_LIMIT = 2'd1,
		REG_OUTLIER    = 2'd2,
		REG_OFFSET     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [ALPHA_W-1:0]         alpha;
		logic [STEP_W-1:0]          step_limit;
		logic [STEP_W-1:0]          outlier_limit;
		logic signed [OFFSET_W-1:0] offset;
	} cfg_t;

endpackage

FILE: rtl/gslef_if.sv
// Valid/ready channel interfaces for samples and results.
interface gslef_sample_if;
	logic                            valid;
	logic                            ready;
	logic [gslef_pkg::ADC_W-1:0]     adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface gslef_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [gslef_pkg::TEMP_W-1:0] temperature;
	logic [gslef_pkg::STATUS_W-1:0]     status;

	modport source (output valid, output temperature, output status, input ready);
	modport sink   (input valid, input temperature, input status, output ready);
endinterface

FILE: rtl/gslef_regs.sv
// APB register file holding the filter configuration.
module gslef_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gslef_pkg::PADDR_W-1:0]       paddr,
	input  logic [gslef_pkg::PDATA_W-1:0]       pwdata,
	output logic [gslef_pkg::PDATA_W-1:0]       prdata,
	output logic                                pready,
	output gslef_pkg::cfg_t                     cfg
);

	gslef_pkg::cfg_t     cfg_q;
	gslef_pkg::reg_idx_t idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = gslef_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha         <= gslef_pkg::ALPHA_RST;
			cfg_q.step_limit    <= gslef_pkg::STEP_LIMIT_RST;
			cfg_q.outlier_limit <= gslef_pkg::OUTLIER_RST;
			cfg_q.offset        <= gslef_pkg::OFFSET_RST;
		end else if (wr_en) begin
			unique case (idx)
				gslef_pkg::REG_ALPHA:      cfg_q.alpha <= pwdata[gslef_pkg::ALPHA_W-1:0];
				gslef_pkg::REG_STEP_LIMIT: cfg_q.step_limit <= pwdata[gslef_pkg::STEP_W-1:0];
				gslef_pkg::REG_OUTLIER:    cfg_q.outlier_limit <= pwdata[gslef_pkg::STEP_W-1:0];
				gslef_pkg::REG_OFFSET:     cfg_q.offset <= pwdata[gslef_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			gslef_pkg::REG_ALPHA:      prdata = gslef_pkg::PDATA_W'(cfg_q.alpha);
			gslef_pkg::REG_STEP_LIMIT: prdata = gslef_pkg::PDATA_W'(cfg_q.step_limit);
			gslef_pkg::REG_OUTLIER:    prdata = gslef_pkg::PDATA_W'(cfg_q.outlier_limit);
			gslef_pkg::REG_OFFSET:     prdata = gslef_pkg::PDATA_W'(unsigned'(cfg_q.offset));
			default:                   prdata = '0;
		endcase
	end

endmodule

FILE: rtl/gslef_front.sv
// Sample accumulator: sums each group of samples and pushes the group sum.
module gslef_front #(
	parameter int SAMPLES_PER_READING = gslef_pkg::SAMPLES_PER_READING_DEF,
	parameter int SUM_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	gslef_sample_if.sink     samples,
	output logic             push,
	output logic [SUM_W-1:0] push_sum,
	input  logic             push_ready
);

	localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic             last;
	logic             accept;
	logic [SUM_W-1:0] sum_next;

	assign last          = (count_q == CNT_LAST);
	// only the closing sample of a group needs room in the queue
	assign samples.ready = !last || push_ready;
	assign accept        = samples.valid && samples.ready;
	assign sum_next      = sum_q + SUM_W'(samples.adc_sample);
	assign push          = accept && last;
	assign push_sum      = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_next;
			end
		end
	end

endmodule

FILE: rtl/gslef_queue.sv
// Short FIFO of group sums between the accumulator and the filter engine.
module gslef_queue #(
	parameter int WIDTH = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = gslef_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/gslef_back.sv
// Filter engine: converts a group sum, gates outliers, clamps and applies the EMA.
module gslef_back #(
	parameter int SAMPLES_PER_READING = gslef_pkg::SAMPLES_PER_READING_DEF,
	parameter int SUM_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gslef_pkg::cfg_t  cfg,
	input  logic             q_valid,
	input  logic [SUM_W-1:0] q_sum,
	output logic             q_pop,
	gslef_result_if.source   results
);

	localparam int TW = gslef_pkg::TEMP_W;
	localparam int SW = gslef_pkg::STEP_W;
	localparam int AW = gslef_pkg::ALPHA_W;
	localparam longint unsigned CONV_K =
		((64'd84480 << gslef_pkg::CONV_SHIFT) + 64'd20475 * 64'(SAMPLES_PER_READING)) /
		(64'd40950 * 64'(SAMPLES_PER_READING));
	localparam int KW = $clog2(CONV_K + 1);
	localparam int PW = SUM_W + KW;
	localparam logic [KW-1:0] K = KW'(CONV_K);
	localparam logic [PW:0] CONV_HALF = (PW+1)'(1) << (gslef_pkg::CONV_SHIFT - 1);
	localparam int MW = SW + AW;

	typedef enum logic [3:0] {
		BK_IDLE  = 4'b0001,
		BK_CONV  = 4'b0010,
		BK_STEP  = 4'b0100,
		BK_WRITE = 4'b1000
	} bk_state_t;

	bk_state_t state_q;

	logic [PW-1:0]          prod_s1;
	logic signed [TW-1:0]   reading_s2;
	logic [SW-1:0]          mag_s2;
	logic                   neg_s2;
	gslef_pkg::status_t     status_s2;
	logic [MW-1:0]          prod_s3;

	logic signed [TW-1:0]   filt_q;
	logic                   primed_q;
	logic                   out_valid_q;
	logic signed [TW-1:0]   temp_q;
	gslef_pkg::status_t     status_q;

	logic [PW:0]            rnd_c;
	logic [TW-1:0]          raw_c;
	logic signed [TW:0]     reading_c;
	logic signed [TW+1:0]   d_c;
	logic [TW+1:0]          absd_c;
	logic                   outlier_c;
	logic                   slew_c;
	logic [AW-1:0]          alpha_c;
	logic [SW:0]            q_c;
	logic signed [TW-1:0]   step_c;
	logic signed [TW:0]     new_c;
	logic                   slot_free;
	gslef_pkg::status_t     status_c;

	// conversion with round half up
	assign rnd_c     = (PW+1)'(prod_s1) + CONV_HALF;
	assign raw_c     = TW'(rnd_c >> gslef_pkg::CONV_SHIFT);
	assign reading_c = $signed({1'b0, raw_c}) + (TW+1)'(cfg.offset);
	assign d_c       = (TW+2)'(reading_c) - (TW+2)'(filt_q);
	assign absd_c    = d_c[TW+1] ? (TW+2)'(-d_c) : (TW+2)'(d_c);
	assign outlier_c = absd_c > (TW+2)'(cfg.outlier_limit);
	assign slew_c    = absd_c > (TW+2)'(cfg.step_limit);

	always_comb begin
		if (!primed_q) begin
			status_c = gslef_pkg::ST_FIRST;
		end else if (outlier_c) begin
			status_c = gslef_pkg::ST_OUTLIER;
		end else if (slew_c) begin
			status_c = gslef_pkg::ST_SLEW;
		end else begin
			status_c = gslef_pkg::ST_NORMAL;
		end
	end

	assign alpha_c = (cfg.alpha > gslef_pkg::ALPHA_ONE) ? gslef_pkg::ALPHA_ONE : cfg.alpha;

	// EMA step, halves away from zero on the magnitude
	assign q_c    = (SW+1)'((prod_s3 + MW'(128)) >> 8);
	assign step_c = neg_s2 ? -$signed(TW'(q_c)) : $signed(TW'(q_c));
	assign new_c  = (TW+1)'(filt_q) + (TW+1)'(step_c);

	assign slot_free = !out_valid_q || results.ready;
	assign q_pop     = (state_q == BK_IDLE) && q_valid;

	assign results.valid       = out_valid_q;
	assign results.temperature = temp_q;
	assign results.status      = status_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s1 <= PW'(q_sum) * PW'(K);
		end
		if (state_q == BK_CONV) begin
			reading_s2 <= reading_c[TW-1:0];
			mag_s2     <= slew_c ? cfg.step_limit : absd_c[SW-1:0];
			neg_s2     <= d_c[TW+1];
			status_s2  <= status_c;
		end
		if (state_q == BK_STEP) begin
			prod_s3 <= MW'(mag_s2) * MW'(alpha_c);
		end
		if ((state_q == BK_WRITE) && slot_free) begin
			status_q <= status_s2;
			unique case (status_s2)
				gslef_pkg::ST_FIRST:   temp_q <= reading_s2;
				gslef_pkg::ST_OUTLIER: temp_q <= filt_q;
				default:               temp_q <= new_c[TW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			filt_q      <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes the slot; otherwise a taken result frees it
			if ((state_q == BK_WRITE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						state_q <= BK_CONV;
					end
				end
				BK_CONV: begin
					state_q <= BK_STEP;
				end
				BK_STEP: begin
					state_q <= BK_WRITE;
				end
				BK_WRITE: begin
					if (slot_free) begin
						primed_q    <= 1'b1;
						state_q     <= BK_IDLE;
						unique case (status_s2)
							gslef_pkg::ST_FIRST:   filt_q <= reading_s2;
							gslef_pkg::ST_OUTLIER: filt_q <= filt_q;
							default:               filt_q <= new_c[TW-1:0];
						endcase
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/gated_slew_limited_ema_filter_unit.sv
// Top level of the gated slew-limited EMA temperature filter.
//
// Takes 12-bit converter samples on "samples" and returns one filtered
// temperature per group of SAMPLES_PER_READING samples on "results", in
// signed 1/256 degree C with a status code (first load, normal, slew
// limited, outlier rejected). Samples are accepted one per cycle; only the
// closing sample of a group can stall, and only when the two-entry queue of
// group sums is full. The filter engine handles one reading at a time (sum x
// conversion constant, outlier test and clamp, alpha multiply, update) and
// pops no new group sum until that reading has entered the result register,
// which waits on results.ready. Configuration (alpha, step_limit,
// outlier_limit, offset) lives on the APB port at byte addresses 0, 4, 8,
// 12 and should only be written while no transaction is in flight. The
// first reading after reset loads the filter directly; the held value is
// output for outliers.
module gated_slew_limited_ema_filter_unit #(
	parameter int SAMPLES_PER_READING = gslef_pkg::SAMPLES_PER_READING_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gslef_sample_if.sink                      samples,
	gslef_result_if.source                    results,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gslef_pkg::PADDR_W-1:0]     paddr,
	input  logic [gslef_pkg::PDATA_W-1:0]     pwdata,
	output logic [gslef_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	// group sum grows by log2 of the group size over the sample width
	localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int SUM_W = gslef_pkg::ADC_W + CNT_W;

	gslef_pkg::cfg_t  cfg;
	logic             push;
	logic [SUM_W-1:0] push_sum;
	logic             push_ready;
	logic             q_pop;
	logic             q_valid;
	logic [SUM_W-1:0] q_sum;

	gslef_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: per-sample accumulation
	gslef_front #(
		.SAMPLES_PER_READING (SAMPLES_PER_READING),
		.SUM_W               (SUM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_sum   (push_sum),
		.push_ready (push_ready)
	);

	// decouples sample intake from the filter engine
	gslef_queue #(
		.WIDTH (SUM_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_sum),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_sum)
	);

	// back: conversion, gating, slew clamp, EMA, result register
	gslef_back #(
		.SAMPLES_PER_READING (SAMPLES_PER_READING),
		.SUM_W               (SUM_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_sum   (q_sum),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule

FILE: rtl/gslef_checker.sv
// Port-level checker for the filter unit, bound to the top level.
`include "gated_slew_limited_ema_filter_unit_macros.svh"

module gslef_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic signed [gslef_pkg::TEMP_W-1:0] temperature,
	input logic [gslef_pkg::STATUS_W-1:0]      status
);

	logic                               res_xfer;
	logic                               seen_first_q;
	logic signed [gslef_pkg::TEMP_W-1:0] last_temp_q;
	logic                               is_first;
	logic                               is_outlier;

	assign res_xfer   = res_valid && res_ready;
	assign is_first   = (status == gslef_pkg::ST_FIRST);
	assign is_outlier = (status == gslef_pkg::ST_OUTLIER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q <= 1'b0;
			last_temp_q  <= '0;
		end else if (res_xfer) begin
			seen_first_q <= 1'b1;
			last_temp_q  <= temperature;
		end
	end

	`GSLEF_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(temperature) && $stable(status), "result changed while stalled")
	`GSLEF_ASSERT_IMP(a_first_leads, clk, arst_n, res_xfer && !seen_first_q, is_first, "first result is not a first load")
	`GSLEF_ASSERT_IMP(a_first_once, clk, arst_n, res_xfer && seen_first_q, !is_first, "filter loaded twice")
	`GSLEF_ASSERT_IMP(a_outlier_holds, clk, arst_n, res_xfer && is_outlier, temperature == last_temp_q, "outlier moved the filter")

endmodule

bind gated_slew_limited_ema_filter_unit gslef_checker u_gslef_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.temperature (results.temperature),
	.status      (results.status)
);
